// ===== src/uesc_pkg.sv =====
`default_nettype none

package uesc_pkg;

    localparam int unsigned MAX_RUN = 6;

    // escape phase codes: held bytes equal the phase value
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_SLASH  = 3'd1;
    localparam logic [2:0] PH_LETTER = 3'd2;
    localparam logic [2:0] PH_DIGIT3 = 3'd5;

    localparam logic [7:0] CH_BSL = 8'h5C;
    localparam logic [7:0] CH_LU  = 8'h75;
    localparam logic [7:0] CH_UU  = 8'h55;
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_9   = 8'h39;
    localparam logic [7:0] CH_LA  = 8'h61;
    localparam logic [7:0] CH_LF  = 8'h66;
    localparam logic [7:0] CH_UA  = 8'h41;
    localparam logic [7:0] CH_UF  = 8'h46;

    localparam logic [15:0] LIM_1B = 16'h007F;
    localparam logic [15:0] LIM_2B = 16'h07FF;

    // bytes produced by one input item, in output order
    typedef struct packed {
        logic [MAX_RUN-1:0][7:0] data;
        logic [2:0]              count;
        logic                    eot;
    } uesc_run_t;

endpackage

`default_nettype wire

// ===== src/uesc_expand.sv =====
`default_nettype none

module uesc_expand
    import uesc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       load,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_eot,
    output uesc_run_t       run
);

    logic [2:0]  phase_reg, phase_next;
    logic [15:0] acc_reg, acc_next;
    logic [7:0]  letter_reg, letter_next;
    logic [7:0]  digits_reg [3];
    logic [7:0]  digits_next [3];

    logic [7:0]  held_cur [8];
    logic [7:0]  held_new [8];
    logic [7:0]  pre [MAX_RUN];
    logic [2:0]  pre_n;
    logic [2:0]  k;
    logic [2:0]  np;
    logic [2:0]  fl_n;
    logic [2:0]  j;
    logic        do_fresh;
    logic        is_u;
    logic        hex_ok;
    logic [3:0]  hex_val;
    logic [15:0] code;
    logic [7:0]  diff;

    always_comb begin
        diff    = 8'h00;
        hex_ok  = 1'b1;
        hex_val = 4'h0;
        if (in_byte >= CH_0 && in_byte <= CH_9) begin
            diff    = in_byte - CH_0;
            hex_val = diff[3:0];
        end else if (in_byte >= CH_LA && in_byte <= CH_LF) begin
            diff    = in_byte - CH_LA + 8'd10;
            hex_val = diff[3:0];
        end else if (in_byte >= CH_UA && in_byte <= CH_UF) begin
            diff    = in_byte - CH_UA + 8'd10;
            hex_val = diff[3:0];
        end else begin
            hex_ok  = 1'b0;
        end
    end

    assign is_u = (in_byte == CH_LU) || (in_byte == CH_UU);
    assign code = {acc_reg[11:0], hex_val};

    always_comb begin
        held_cur[0] = CH_BSL;
        held_cur[1] = letter_reg;
        held_cur[2] = digits_reg[0];
        held_cur[3] = digits_reg[1];
        held_cur[4] = digits_reg[2];
        held_cur[5] = 8'h00;
        held_cur[6] = 8'h00;
        held_cur[7] = 8'h00;

        for (int i = 0; i < MAX_RUN; i++) begin
            pre[i] = 8'h00;
        end
        for (int i = 0; i < 3; i++) begin
            digits_next[i] = digits_reg[i];
        end
        pre_n       = 3'd0;
        k           = 3'd0;
        do_fresh    = 1'b0;
        np          = phase_reg;
        acc_next    = acc_reg;
        letter_next = letter_reg;

        if (phase_reg == PH_SLASH) begin
            if (is_u) begin
                letter_next = in_byte;
                np          = PH_LETTER;
            end else begin
                do_fresh = 1'b1;
                k        = phase_reg;
            end
        end else if (phase_reg >= PH_LETTER && phase_reg <= PH_DIGIT3) begin
            if (!hex_ok) begin
                do_fresh = 1'b1;
                k        = phase_reg;
            end else if (phase_reg < PH_DIGIT3) begin
                digits_next[2'(phase_reg - PH_LETTER)] = in_byte;
                acc_next = code;
                np       = phase_reg + 3'd1;
            end else begin
                np       = PH_IDLE;
                acc_next = 16'h0000;
                if (code <= LIM_1B) begin
                    pre[0] = code[7:0];
                    pre_n  = 3'd1;
                end else if (code <= LIM_2B) begin
                    pre[0] = {3'b110, code[10:6]};
                    pre[1] = {2'b10, code[5:0]};
                    pre_n  = 3'd2;
                end else begin
                    pre[0] = {4'b1110, code[15:12]};
                    pre[1] = {2'b10, code[11:6]};
                    pre[2] = {2'b10, code[5:0]};
                    pre_n  = 3'd3;
                end
            end
        end else begin
            // idle, and the unused phase codes
            do_fresh = 1'b1;
            k        = PH_IDLE;
        end

        if (do_fresh) begin
            for (int i = 0; i < MAX_RUN; i++) begin
                if (3'(i) < k) begin
                    pre[i] = held_cur[i];
                end
            end
            acc_next = 16'h0000;
            if (in_byte == CH_BSL) begin
                np    = PH_SLASH;
                pre_n = k;
            end else begin
                np     = PH_IDLE;
                pre[k] = in_byte;
                pre_n  = k + 3'd1;
            end
        end

        held_new[0] = CH_BSL;
        held_new[1] = letter_next;
        held_new[2] = digits_next[0];
        held_new[3] = digits_next[1];
        held_new[4] = digits_next[2];
        held_new[5] = 8'h00;
        held_new[6] = 8'h00;
        held_new[7] = 8'h00;

        // end of text flushes whatever escape is still open
        fl_n       = 3'd0;
        phase_next = np;
        if (in_eot && np != PH_IDLE) begin
            fl_n       = np;
            phase_next = PH_IDLE;
            acc_next   = 16'h0000;
        end

        for (int i = 0; i < MAX_RUN; i++) begin
            j = 3'(i) - pre_n;
            if (3'(i) < pre_n) begin
                run.data[i] = pre[i];
            end else if (j < fl_n) begin
                run.data[i] = held_new[j];
            end else begin
                run.data[i] = 8'h00;
            end
        end
        run.count = pre_n + fl_n;
        run.eot   = in_eot;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            acc_reg    <= 16'h0000;
            letter_reg <= 8'h00;
        end else if (load) begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            letter_reg <= letter_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < 3; i++) begin
                digits_reg[i] <= digits_next[i];
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/uesc_outbuf.sv =====
`default_nettype none

module uesc_outbuf
    import uesc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       load,
    input  wire uesc_run_t  run,
    output logic            free,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_run_last,
    output logic            m_text_last
);

    logic [MAX_RUN-1:0][7:0] data_reg, data_next;
    logic [2:0]              count_reg, count_next;
    logic                    eot_reg, eot_next;
    logic                    xfer;

    assign xfer        = m_valid && m_ready;
    assign m_valid     = (count_reg != 3'd0);
    assign m_out_byte  = data_reg[0];
    assign m_run_last  = (count_reg == 3'd1);
    assign m_text_last = (count_reg == 3'd1) && eot_reg;
    // a new run may land once the last byte of the current one leaves
    assign free        = (count_reg == 3'd0) || ((count_reg == 3'd1) && m_ready);

    always_comb begin
        data_next  = data_reg;
        count_next = count_reg;
        eot_next   = eot_reg;
        if (load) begin
            data_next  = run.data;
            count_next = run.count;
            eot_next   = run.eot;
        end else if (xfer) begin
            for (int i = 0; i < MAX_RUN - 1; i++) begin
                data_next[i] = data_reg[i+1];
            end
            data_next[MAX_RUN-1] = 8'h00;
            count_next = count_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 3'd0;
            eot_reg   <= 1'b0;
        end else begin
            count_reg <= count_next;
            eot_reg   <= eot_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

// ===== src/unicode_escape_to_utf8.sv =====
// path: an input byte is registered in the input holding register, then its run in the output run buffer
// throughput: one input byte per cycle while each item yields at most one byte and m_ready is high;
//   an item yielding n bytes holds the output run buffer until all n of its bytes have been taken
// reset: synchronous, active low; clears valid flags, escape phase, code and letter;
//   the held digit bytes are not reset
`default_nettype none

module unicode_escape_to_utf8
    import uesc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_in_byte,
    input  wire logic       s_end_of_text,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_run_last,
    output logic            m_text_last
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_eot_reg;
    logic       free;
    logic       load;
    logic       accept;
    uesc_run_t  run;

    assign load    = in_valid_reg && free;
    assign s_ready = !in_valid_reg || free;
    assign accept  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (load) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_byte_reg <= s_in_byte;
            in_eot_reg  <= s_end_of_text;
        end
    end

    uesc_expand u_expand (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (load),
        .in_byte (in_byte_reg),
        .in_eot  (in_eot_reg),
        .run     (run)
    );

    uesc_outbuf u_outbuf (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (load),
        .run         (run),
        .free        (free),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_run_last  (m_run_last),
        .m_text_last (m_text_last)
    );

    a_text_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_text_last |-> m_run_last)
        else $error("text_last without run_last");

    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_run_last |=> m_valid)
        else $error("gap inside an output run");

    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !load |=> in_valid_reg && $stable(in_byte_reg))
        else $error("pending input byte lost");

endmodule

`default_nettype wire
